/* design/cle_pkg.sv */
// cle_pkg: shared types and codes of the console line editor
// holds request and echo action codes, register indexes, reset values and
// the config and result structs; no dependencies
package cle_pkg;

  // default line storage depth
  localparam int LINE_CAPACITY_DEF = 256;

  // request codes
  localparam logic [3:0] REQ_INSERT    = 4'd0;
  localparam logic [3:0] REQ_LEFT      = 4'd1;
  localparam logic [3:0] REQ_RIGHT     = 4'd2;
  localparam logic [3:0] REQ_HOME      = 4'd3;
  localparam logic [3:0] REQ_END       = 4'd4;
  localparam logic [3:0] REQ_BACKSPACE = 4'd5;
  localparam logic [3:0] REQ_DELETE    = 4'd6;
  localparam logic [3:0] REQ_TOGGLE    = 4'd7;
  localparam logic [3:0] REQ_CLEAR     = 4'd8;
  localparam logic [3:0] REQ_CANCEL    = 4'd9;
  localparam logic [3:0] REQ_REFRESH   = 4'd10;
  localparam logic [3:0] REQ_READ      = 4'd11;

  // echo action codes
  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_CHAR    = 4'd1;
  localparam logic [3:0] ACT_INSCHAR = 4'd2;
  localparam logic [3:0] ACT_BACK1   = 4'd3;
  localparam logic [3:0] ACT_FWD1    = 4'd4;
  localparam logic [3:0] ACT_BACKN   = 4'd5;
  localparam logic [3:0] ACT_FWDN    = 4'd6;
  localparam logic [3:0] ACT_BACKDEL = 4'd7;
  localparam logic [3:0] ACT_DEL     = 4'd8;
  localparam logic [3:0] ACT_REDRAW  = 4'd9;

  // configuration register indexes
  localparam logic CFG_MAX_LENGTH    = 1'b0;
  localparam logic CFG_PROMPT_LENGTH = 1'b1;

  // configuration reset values
  localparam logic [8:0] MAX_LENGTH_RST    = 9'd256;
  localparam logic [5:0] PROMPT_LENGTH_RST = 6'd4;

  typedef struct packed {
    logic [8:0] max_length;
    logic [5:0] prompt_length;
  } cfg_t;

  typedef struct packed {
    logic [3:0] echo_action;
    logic [7:0] echo_char;
    logic [8:0] move_count;
    logic [8:0] echo_column;
    logic       reposition;
    logic [8:0] line_length;
    logic [8:0] cursor_now;
    logic       overwrite_now;
    logic [7:0] read_char;
    logic       read_valid;
  } res_t;

endpackage

/* design/cle_line_ram.sv */
// cle_line_ram: character store of the line, one write and one read port
// synchronous read, rdata registered while re is high; no dependencies
module cle_line_ram #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/cle_engine.sv */
// cle_engine: edit sequencer with line length, cursor and overwrite state
// shifts stored characters through cle_line_ram one per cycle
// depends on cle_pkg and cle_line_ram
module cle_engine #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [3:0]        req_type,
  input  logic [7:0]        char_value,
  input  logic [7:0]        read_index,
  input  cle_pkg::cfg_t     cfg,
  input  logic              slot_free,
  output logic              idle,
  output logic              done,
  output cle_pkg::res_t     res
);

  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);
  localparam int CW = (LW > 9) ? LW : 9;
  localparam logic [CW-1:0] CAP_C = CW'(LINE_CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_UP    = 7'b0000010,
    S_DOWN  = 7'b0000100,
    S_FLUSH = 7'b0001000,
    S_PUT   = 7'b0010000,
    S_RD    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t         state;
  logic [LW-1:0]  len;
  logic [LW-1:0]  cur;
  logic           ovr;
  logic           pend;
  logic           up;
  logic [LW-1:0]  src;
  logic [LW-1:0]  stop;
  logic [AW-1:0]  dst;
  logic [AW-1:0]  put_addr;
  logic [7:0]     put_char;

  // decode of the accepted item
  state_t         go;
  logic [LW-1:0]  len_next;
  logic [LW-1:0]  cur_next;
  logic           ovr_next;
  logic [LW-1:0]  src_next;
  logic [LW-1:0]  stop_next;
  cle_pkg::res_t  res_next;

  // memory port
  logic           we;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;
  logic           re;
  logic [AW-1:0]  raddr;
  logic [7:0]     rdata;

  always_comb begin
    logic [3:0]    req_eff;
    logic [CW-1:0] lim;
    logic          full;
    logic [3:0]    act;
    logic [7:0]    ech;
    logic [LW-1:0] cnt;
    logic          repos;
    logic          rvalid;
    req_eff   = req_type;
    if (req_type == cle_pkg::REQ_BACKSPACE && ovr) begin
      req_eff = cle_pkg::REQ_LEFT;
    end
    lim       = (CW'(cfg.max_length) > CAP_C) ? CAP_C : CW'(cfg.max_length);
    full      = CW'(len) >= lim;
    len_next  = len;
    cur_next  = cur;
    ovr_next  = ovr;
    act       = cle_pkg::ACT_NONE;
    ech       = 8'd0;
    cnt       = '0;
    repos     = 1'b0;
    rvalid    = 1'b0;
    go        = S_DONE;
    src_next  = '0;
    stop_next = '0;
    unique case (req_eff)
      cle_pkg::REQ_INSERT: begin
        if (!full) begin
          ech      = char_value;
          cur_next = cur + 1'b1;
          if (ovr && cur != len) begin
            act = cle_pkg::ACT_CHAR;
            go  = S_PUT;
          end else begin
            len_next  = len + 1'b1;
            act       = (cur == len) ? cle_pkg::ACT_CHAR : cle_pkg::ACT_INSCHAR;
            go        = (cur == len) ? S_PUT : S_UP;
            src_next  = len - 1'b1;
            stop_next = cur;
          end
        end
      end
      cle_pkg::REQ_LEFT: begin
        if (cur != '0) begin
          cur_next = cur - 1'b1;
          act      = cle_pkg::ACT_BACK1;
        end
      end
      cle_pkg::REQ_RIGHT: begin
        if (cur != len) begin
          cur_next = cur + 1'b1;
          act      = cle_pkg::ACT_FWD1;
        end
      end
      cle_pkg::REQ_HOME: begin
        if (cur != '0) begin
          cnt = cur;
          act = cle_pkg::ACT_BACKN;
        end
        cur_next = '0;
      end
      cle_pkg::REQ_END: begin
        if (cur != len) begin
          cnt = len - cur;
          act = cle_pkg::ACT_FWDN;
        end
        cur_next = len;
      end
      cle_pkg::REQ_BACKSPACE: begin
        if (cur != '0) begin
          cur_next = cur - 1'b1;
          len_next = len - 1'b1;
          act      = cle_pkg::ACT_BACKDEL;
          if (cur != len) begin
            go        = S_DOWN;
            src_next  = cur;
            stop_next = len - 1'b1;
          end
        end
      end
      cle_pkg::REQ_DELETE: begin
        if (cur != len) begin
          len_next = len - 1'b1;
          act      = cle_pkg::ACT_DEL;
          if (cur + 1'b1 != len) begin
            go        = S_DOWN;
            src_next  = cur + 1'b1;
            stop_next = len - 1'b1;
          end
        end
      end
      cle_pkg::REQ_TOGGLE: begin
        ovr_next = !ovr;
      end
      cle_pkg::REQ_CLEAR: begin
        len_next = '0;
        cur_next = '0;
        act      = cle_pkg::ACT_REDRAW;
      end
      cle_pkg::REQ_CANCEL: begin
        len_next = '0;
        cur_next = '0;
        ovr_next = 1'b0;
        act      = cle_pkg::ACT_REDRAW;
      end
      cle_pkg::REQ_REFRESH: begin
        act   = cle_pkg::ACT_REDRAW;
        repos = cur != len;
      end
      cle_pkg::REQ_READ: begin
        rvalid = CW'(read_index) < CW'(len);
        go     = S_RD;
      end
      default: begin
      end
    endcase
    res_next.echo_action   = act;
    res_next.echo_char     = ech;
    res_next.move_count    = 9'(cnt);
    res_next.echo_column   = 9'(cfg.prompt_length) + 9'(cur_next) + 9'd1;
    res_next.reposition    = repos;
    res_next.line_length   = 9'(len_next);
    res_next.cursor_now    = 9'(cur_next);
    res_next.overwrite_now = ovr_next;
    res_next.read_char     = 8'd0;
    res_next.read_valid    = rvalid;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      cur   <= '0;
      ovr   <= 1'b0;
      pend  <= 1'b0;
      up    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= go;
            len   <= len_next;
            cur   <= cur_next;
            ovr   <= ovr_next;
            pend  <= 1'b0;
            up    <= go == S_UP;
          end
        end
        S_UP, S_DOWN: begin
          pend <= 1'b1;
          if (src == stop) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          pend  <= 1'b0;
          state <= up ? S_PUT : S_DONE;
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_RD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // shift pointers and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          res      <= res_next;
          src      <= src_next;
          stop     <= stop_next;
          put_addr <= AW'(cur);
          put_char <= char_value;
        end
      end
      S_UP: begin
        dst <= AW'(src + 1'b1);
        src <= src - 1'b1;
      end
      S_DOWN: begin
        dst <= AW'(src - 1'b1);
        src <= src + 1'b1;
      end
      S_RD: begin
        res.read_char <= res.read_valid ? rdata : 8'd0;
      end
      default: begin
      end
    endcase
  end

  // write lands two places behind the read, so no forwarding is needed
  assign re    = (state == S_IDLE && start) || state == S_UP || state == S_DOWN;
  assign raddr = (state == S_IDLE) ? AW'(read_index) : AW'(src);
  assign we    = (pend && (state == S_UP || state == S_DOWN || state == S_FLUSH))
                 || state == S_PUT;
  assign waddr = (state == S_PUT) ? put_addr : dst;
  assign wdata = (state == S_PUT) ? put_char : rdata;

  cle_line_ram #(
    .DEPTH (LINE_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idle = state == S_IDLE;
  assign done = state == S_DONE && slot_free;

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cur <= len)
    else $error("cursor beyond line end");

  a_len_in_store: assert property (@(posedge clk) disable iff (rst)
    CW'(len) <= CAP_C)
    else $error("line longer than store");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> waddr != raddr)
    else $error("shift read and write hit one entry");

  a_flush_to_put: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && up) |=> state == S_PUT)
    else $error("insert shift not followed by character write");

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE)
    else $error("item taken while busy");

endmodule

/* design/console_line_editor.sv */
// console_line_editor: top level of the editable command line
// holds the configuration registers and the result register
// depends on cle_pkg and cle_engine
//
// usage
//   key events enter on the input channel (in_valid, in_stall, req_type,
//   char_value, read_index); one result item leaves on the output channel
//   (out_valid, out_stall and the echo and line state fields) per event
//   an item is taken on a rising edge with valid high and stall low
//   cursor moves, toggles, clears, refreshes, ignored inserts and a backspace
//   or delete that moves no stored character go straight to the done state,
//   which raises out_valid; a read first passes the read state, an append
//   and an overwrite the character write state; an insert or delete inside
//   the line shifts the stored characters one per cycle through the line
//   memory, an insert in the shift-up, flush and character write states, a
//   delete or backspace in the shift-down and flush states
//   in_stall is high while an item is in work; the next item is taken the
//   cycle after out_valid rises, and the last result may still wait in the
//   output register
//   when out_stall is high the result holds in the output register and a
//   finished item waits in the sequencer until the register frees
//   reset empties the line, puts the cursor at 0, selects insert mode and
//   loads max_length 256 and prompt_length 4; line memory is not cleared
//   configuration writes (cfg_write, cfg_index, cfg_data) land at once
module console_line_editor #(
  parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data,
  // key event channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] req_type,
  input  logic [7:0] char_value,
  input  logic [7:0] read_index,
  // echo result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] echo_action,
  output logic [7:0] echo_char,
  output logic [8:0] move_count,
  output logic [8:0] echo_column,
  output logic       reposition,
  output logic [8:0] line_length,
  output logic [8:0] cursor_now,
  output logic       overwrite_now,
  output logic [7:0] read_char,
  output logic       read_valid
);

  cle_pkg::cfg_t cfg;
  cle_pkg::res_t eng_res;
  cle_pkg::res_t out_res;
  logic          eng_idle;
  logic          eng_done;
  logic          start;
  logic          slot_free;

  // configuration registers, to be written only while no item is in work; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length    <= cle_pkg::MAX_LENGTH_RST;
      cfg.prompt_length <= cle_pkg::PROMPT_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cle_pkg::CFG_MAX_LENGTH:    cfg.max_length    <= cfg_data;
        cle_pkg::CFG_PROMPT_LENGTH: cfg.prompt_length <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // input side: take an item whenever the sequencer is idle
  assign in_stall = !eng_idle;
  assign start    = in_valid && eng_idle;

  // output register frees when empty or being taken this cycle
  assign slot_free = !out_valid || !out_stall;

  cle_engine #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .char_value (char_value),
    .read_index (read_index),
    .cfg        (cfg),
    .slot_free  (slot_free),
    .idle       (eng_idle),
    .done       (eng_done),
    .res        (eng_res)
  );

  // result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded only when the register is free
  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_res <= eng_res;
    end
  end

  assign echo_action   = out_res.echo_action;
  assign echo_char     = out_res.echo_char;
  assign move_count    = out_res.move_count;
  assign echo_column   = out_res.echo_column;
  assign reposition    = out_res.reposition;
  assign line_length   = out_res.line_length;
  assign cursor_now    = out_res.cursor_now;
  assign overwrite_now = out_res.overwrite_now;
  assign read_char     = out_res.read_char;
  assign read_valid    = out_res.read_valid;

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for console_line_editor
// walks a directed table of key events, then random typing and editing phases under
// several register settings; depends on cle_pkg and the design files
module tb;

  localparam int LINE_CAP = cle_pkg::LINE_CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 2500000;
  localparam int SETTLE = 16;
  localparam int HOLD_CYCLES = 600;
  localparam int ECHO_DEPTH = 16;

  // request codes the block leaves unused
  localparam logic [3:0] REQ_SPARE_LO = 4'd12;
  localparam logic [3:0] REQ_SPARE_HI = 4'd15;

  // directed row: key event plus, where obvious, the action, length and cursor it gives
  typedef struct packed {
    logic [3:0] req;
    logic [7:0] ch;
    logic [7:0] idx;
    logic       typed;
    logic [3:0] act;
    logic [8:0] len;
    logic [8:0] cur;
  } key_row_t;

  localparam int DIR_ROWS = 28;
  localparam key_row_t DIR_TABLE [DIR_ROWS] = '{
    '{cle_pkg::REQ_LEFT,      8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{cle_pkg::REQ_BACKSPACE, 8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{cle_pkg::REQ_DELETE,    8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{cle_pkg::REQ_END,       8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{cle_pkg::REQ_INSERT,    8'h00, 8'd0,  1'b1, cle_pkg::ACT_CHAR,    9'd1, 9'd1},
    '{cle_pkg::REQ_INSERT,    8'hff, 8'd0,  1'b1, cle_pkg::ACT_CHAR,    9'd2, 9'd2},
    '{cle_pkg::REQ_INSERT,    8'ha5, 8'd0,  1'b1, cle_pkg::ACT_CHAR,    9'd3, 9'd3},
    '{cle_pkg::REQ_HOME,      8'h00, 8'd0,  1'b1, cle_pkg::ACT_BACKN,   9'd3, 9'd0},
    '{cle_pkg::REQ_HOME,      8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd3, 9'd0},
    '{cle_pkg::REQ_INSERT,    8'h5a, 8'd0,  1'b1, cle_pkg::ACT_INSCHAR, 9'd4, 9'd1},
    '{cle_pkg::REQ_RIGHT,     8'h00, 8'd0,  1'b1, cle_pkg::ACT_FWD1,    9'd4, 9'd2},
    '{cle_pkg::REQ_END,       8'h00, 8'd0,  1'b1, cle_pkg::ACT_FWDN,    9'd4, 9'd4},
    '{cle_pkg::REQ_RIGHT,     8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd4, 9'd4},
    '{cle_pkg::REQ_LEFT,      8'h00, 8'd0,  1'b1, cle_pkg::ACT_BACK1,   9'd4, 9'd3},
    '{cle_pkg::REQ_BACKSPACE, 8'h00, 8'd0,  1'b1, cle_pkg::ACT_BACKDEL, 9'd3, 9'd2},
    '{cle_pkg::REQ_DELETE,    8'h00, 8'd0,  1'b1, cle_pkg::ACT_DEL,     9'd2, 9'd2},
    '{cle_pkg::REQ_READ,      8'h00, 8'd1,  1'b0, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{cle_pkg::REQ_READ,      8'h00, 8'd3,  1'b1, cle_pkg::ACT_NONE,    9'd2, 9'd2},
    '{cle_pkg::REQ_TOGGLE,    8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd2, 9'd2},
    '{cle_pkg::REQ_HOME,      8'h00, 8'd0,  1'b1, cle_pkg::ACT_BACKN,   9'd2, 9'd0},
    '{cle_pkg::REQ_INSERT,    8'h41, 8'd0,  1'b1, cle_pkg::ACT_CHAR,    9'd2, 9'd1},
    '{cle_pkg::REQ_BACKSPACE, 8'h00, 8'd0,  1'b1, cle_pkg::ACT_BACK1,   9'd2, 9'd0},
    '{cle_pkg::REQ_REFRESH,   8'h00, 8'd0,  1'b0, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{cle_pkg::REQ_CLEAR,     8'h00, 8'd0,  1'b1, cle_pkg::ACT_REDRAW,  9'd0, 9'd0},
    '{cle_pkg::REQ_INSERT,    8'h42, 8'd0,  1'b1, cle_pkg::ACT_CHAR,    9'd1, 9'd1},
    '{cle_pkg::REQ_CANCEL,    8'h00, 8'd0,  1'b1, cle_pkg::ACT_REDRAW,  9'd0, 9'd0},
    '{REQ_SPARE_LO,           8'h00, 8'd0,  1'b1, cle_pkg::ACT_NONE,    9'd0, 9'd0},
    '{REQ_SPARE_HI,           8'hff, 8'hff, 1'b1, cle_pkg::ACT_NONE,    9'd0, 9'd0}
  };

  // random phases: register setting, length and whether the mix favours typing
  localparam int PHASES = 8;
  localparam int RAND_PHASE = 6;
  localparam int HOLD_PHASE = 4;
  localparam int DRAIN_PHASE = 6;
  localparam int PH_MAX [PHASES]    = '{256, 1, 0, 511, 8, 300, 0, 256};
  localparam int PH_PROMPT [PHASES] = '{4, 0, 63, 63, 17, 0, 0, 63};
  localparam int PH_ITEMS [PHASES]  = '{250, 150, 50, 450, 200, 220, 200, 180};
  localparam bit PH_FILL [PHASES]   = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  // cumulative weights, one slot per request code in code order, last slot the spare codes
  localparam int NORM_CUM [13] = '{40, 48, 56, 60, 64, 72, 78, 81, 83, 85, 88, 98, 100};
  localparam int FILL_CUM [13] = '{78, 81, 83, 84, 86, 88, 90, 91, 91, 91, 92, 99, 100};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] req_type = '0;
  logic [7:0] char_value = '0;
  logic [7:0] read_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] echo_action;
  logic [7:0] echo_char;
  logic [8:0] move_count;
  logic [8:0] echo_column;
  logic       reposition;
  logic [8:0] line_length;
  logic [8:0] cursor_now;
  logic       overwrite_now;
  logic [7:0] read_char;
  logic       read_valid;

  console_line_editor dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .char_value(char_value), .read_index(read_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .echo_action(echo_action), .echo_char(echo_char), .move_count(move_count),
    .echo_column(echo_column), .reposition(reposition), .line_length(line_length),
    .cursor_now(cursor_now), .overwrite_now(overwrite_now),
    .read_char(read_char), .read_valid(read_valid)
  );

  always #10 clk = ~clk;

  // shadow of the editor: line contents, cursor, mode and registers
  logic [7:0] line_mem [LINE_CAP];
  bit         written_q [LINE_CAP];
  logic [8:0] len_q = '0;
  logic [8:0] cur_q = '0;
  logic       ovw_q = 1'b0;
  logic [8:0] max_len_q = cle_pkg::MAX_LENGTH_RST;
  logic [5:0] prompt_q = cle_pkg::PROMPT_LENGTH_RST;

  // ring of predicted echoes, oldest at echo_head
  cle_pkg::res_t echo_q [ECHO_DEPTH];
  int echo_head = 0;
  int echo_tail = 0;

  int fails = 0;
  int checked = 0;
  int keys_sent = 0;
  int cfg_writes = 0;
  int longest = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_reqs = 0;
  int holds_done = 0;

  initial begin
    for (int i = 0; i < LINE_CAP; i++) begin
      line_mem[i] = '0;
      written_q[i] = 1'b0;
    end
  end

  // close the gap left by a removed character
  task automatic drop_char(input int pos);
    int i;
    for (i = pos; i + 1 < len_q; i++)
      line_mem[i] = line_mem[i + 1];
    len_q = len_q - 9'd1;
  endtask

  // apply one key event to the shadow line and work out the echo it gives
  task automatic edit_line(input logic [3:0] req, input logic [7:0] ch,
                           input logic [7:0] idx, output cle_pkg::res_t r);
    logic [3:0] op;
    int limit;
    int i;
    r = '0;
    limit = (max_len_q > LINE_CAP) ? LINE_CAP : max_len_q;
    op = req;
    // in overwrite mode backspace only moves the cursor
    if (op == cle_pkg::REQ_BACKSPACE && ovw_q)
      op = cle_pkg::REQ_LEFT;
    case (op)
      cle_pkg::REQ_INSERT: begin
        // a full line swallows the keystroke, whatever the mode
        if (len_q < limit) begin
          if (ovw_q && cur_q != len_q) begin
            line_mem[cur_q] = ch;
            written_q[cur_q] = 1'b1;
            cur_q = cur_q + 9'd1;
            r.echo_action = cle_pkg::ACT_CHAR;
          end else begin
            for (i = len_q; i > cur_q; i--) begin
              line_mem[i] = line_mem[i - 1];
              written_q[i] = 1'b1;
            end
            line_mem[cur_q] = ch;
            written_q[cur_q] = 1'b1;
            len_q = len_q + 9'd1;
            cur_q = cur_q + 9'd1;
            r.echo_action = (cur_q == len_q) ? cle_pkg::ACT_CHAR : cle_pkg::ACT_INSCHAR;
          end
          r.echo_char = ch;
        end
      end
      cle_pkg::REQ_LEFT: if (cur_q != 0) begin
        cur_q = cur_q - 9'd1;
        r.echo_action = cle_pkg::ACT_BACK1;
      end
      cle_pkg::REQ_RIGHT: if (cur_q != len_q) begin
        cur_q = cur_q + 9'd1;
        r.echo_action = cle_pkg::ACT_FWD1;
      end
      cle_pkg::REQ_HOME: begin
        if (cur_q != 0) begin
          r.move_count = cur_q;
          r.echo_action = cle_pkg::ACT_BACKN;
        end
        cur_q = '0;
      end
      cle_pkg::REQ_END: begin
        if (cur_q != len_q) begin
          r.move_count = len_q - cur_q;
          r.echo_action = cle_pkg::ACT_FWDN;
        end
        cur_q = len_q;
      end
      cle_pkg::REQ_BACKSPACE: if (cur_q != 0) begin
        cur_q = cur_q - 9'd1;
        drop_char(cur_q);
        r.echo_action = cle_pkg::ACT_BACKDEL;
      end
      cle_pkg::REQ_DELETE: if (cur_q != len_q) begin
        drop_char(cur_q);
        r.echo_action = cle_pkg::ACT_DEL;
      end
      cle_pkg::REQ_TOGGLE: ovw_q = ~ovw_q;
      cle_pkg::REQ_CLEAR: begin
        len_q = '0;
        cur_q = '0;
        r.echo_action = cle_pkg::ACT_REDRAW;
      end
      cle_pkg::REQ_CANCEL: begin
        ovw_q = 1'b0;
        len_q = '0;
        cur_q = '0;
        r.echo_action = cle_pkg::ACT_REDRAW;
      end
      cle_pkg::REQ_REFRESH: begin
        r.echo_action = cle_pkg::ACT_REDRAW;
        r.reposition = (cur_q != len_q);
      end
      cle_pkg::REQ_READ: if (idx < len_q) begin
        r.read_valid = 1'b1;
        r.read_char = line_mem[idx];
      end
      default: ;
    endcase
    r.echo_column = {3'b000, prompt_q} + cur_q + 9'd1;
    r.line_length = len_q;
    r.cursor_now = cur_q;
    r.overwrite_now = ovw_q;
    if (len_q > longest)
      longest = len_q;
  endtask

  // offer one key event, hold it until taken, then record its echo
  task automatic send_key(input logic [3:0] req, input logic [7:0] ch, input logic [7:0] idx,
                          input logic typed, input logic [3:0] t_act,
                          input logic [8:0] t_len, input logic [8:0] t_cur);
    cle_pkg::res_t r;
    in_valid <= 1'b1;
    req_type <= req;
    char_value <= ch;
    read_index <= idx;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    edit_line(req, ch, idx, r);
    if (typed) begin
      r.echo_action = t_act;
      r.line_length = t_len;
      r.cursor_now = t_cur;
    end
    echo_q[echo_tail % ECHO_DEPTH] = r;
    echo_tail++;
    keys_sent++;
  endtask

  // sender works in bursts; a burst ends with a gap, sometimes none at all
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // stop offering and wait until every echo is back and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (echo_tail != echo_head)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one register write, then a pause with the write port quiet
  task automatic set_reg(input logic idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[8:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == cle_pkg::CFG_MAX_LENGTH)
      max_len_q = val[8:0];
    else
      prompt_q = val[5:0];
    cfg_writes++;
    @(posedge clk);
  endtask

  // weighted pick of the next key event
  task automatic next_key(input bit fill, output logic [3:0] req,
                          output logic [7:0] ch, output logic [7:0] idx);
    int roll;
    int sel;
    roll = $urandom_range(0, 99);
    sel = 12;
    for (int k = 12; k >= 0; k--)
      if (roll < (fill ? FILL_CUM[k] : NORM_CUM[k]))
        sel = k;
    if (sel == 12)
      req = 4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    else
      req = 4'(sel);
    ch = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0 && len_q != 0)
      idx = 8'($urandom_range(0, len_q - 1));
    else
      idx = 8'($urandom_range(0, 255));
    // never read a cell that was never filled: the first four came from the directed part
    if (idx >= len_q && !written_q[idx])
      idx = {6'b0, idx[1:0]};
  endtask

  // stimulus
  initial begin
    key_row_t row;
    logic [3:0] rq;
    logic [7:0] rc;
    logic [7:0] ri;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: edges of the line, every request, both modes
    for (int n = 0; n < DIR_ROWS; n++) begin
      row = DIR_TABLE[n];
      send_key(row.req, row.ch, row.idx, row.typed, row.act, row.len, row.cur);
      pace_sender();
    end

    // random phases, registers rewritten only once the block has gone quiet
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      if (p == RAND_PHASE) begin
        set_reg(cle_pkg::CFG_MAX_LENGTH, $urandom_range(1, LINE_CAP));
        set_reg(cle_pkg::CFG_PROMPT_LENGTH, $urandom_range(0, 63));
      end else begin
        set_reg(cle_pkg::CFG_MAX_LENGTH, PH_MAX[p]);
        set_reg(cle_pkg::CFG_PROMPT_LENGTH, PH_PROMPT[p]);
      end
      for (int n = 0; n < PH_ITEMS[p]; n++) begin
        // long hold-off at the receiver while items keep coming
        if (p == HOLD_PHASE && n == 40)
          hold_reqs++;
        // a pause until every echo has drained
        if (p == DRAIN_PHASE && n == 100)
          wait_idle();
        next_key(PH_FILL[p], rq, rc, ri);
        send_key(rq, rc, ri, 1'b0, cle_pkg::ACT_NONE, '0, '0);
        pace_sender();
      end
    end

    wait_idle();
    $display("sent %0d key events over %0d register writes, %0d echoes compared",
             keys_sent, cfg_writes, checked);
    $display("longest line reached %0d characters", longest);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // receiver: its own stall pattern, which moves through four modes in turn,
  // with a long hold-off whenever the sender asks for one
  int rx_cycle = 0;
  int stall_burst = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_done < hold_reqs) begin
      out_stall <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) begin
        holds_done++;
        hold_cnt = 0;
      end
    end else begin
      case ((rx_cycle / 300) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= (rx_cycle % 3 == 0);
        default: begin
          if (stall_burst > 0) begin
            stall_burst--;
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0)
              stall_burst = $urandom_range(1, 40);
          end
        end
      endcase
    end
    rx_cycle++;
  end

  task automatic check_field(input string nm, input logic [8:0] e, input logic [8:0] a);
    if (e !== a) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
    end
  endtask

  // compare each echo taken with the oldest one predicted
  always @(posedge clk) begin
    cle_pkg::res_t e;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (echo_tail == echo_head) begin
        fails++;
        $display("%0t: echo with nothing expected, action %0d", $time, echo_action);
      end else begin
        e = echo_q[echo_head % ECHO_DEPTH];
        echo_head++;
        check_field("echo_action", e.echo_action, echo_action);
        check_field("echo_char", e.echo_char, echo_char);
        check_field("move_count", e.move_count, move_count);
        check_field("echo_column", e.echo_column, echo_column);
        check_field("reposition", e.reposition, reposition);
        check_field("line_length", e.line_length, line_length);
        check_field("cursor_now", e.cursor_now, cursor_now);
        check_field("overwrite_now", e.overwrite_now, overwrite_now);
        check_field("read_char", e.read_char, read_char);
        check_field("read_valid", e.read_valid, read_valid);
        checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d echoes outstanding", cycles,
               echo_tail - echo_head);
      $display("FAIL");
      $finish;
    end
  end

endmodule

/* console_line_editor.f */
design/cle_pkg.sv
design/cle_line_ram.sv
design/cle_engine.sv
design/console_line_editor.sv
tb/tb.sv
